// ===== rtl/acr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the atmospheric correction reflectance block.
// Used by acr_lane and atmos_coef_reflectance; depends on nothing.
package acr_pkg;

    localparam int NUM_OUT         = 4;
    localparam int COEF_BITS       = 32;
    localparam int SCALE_BITS      = 16;
    localparam int NODATA_BITS     = 16;
    localparam int REFL_BITS       = 24;
    localparam int QBITS           = 25;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_IDX_BITS    = 2;
    // Lane register stages: capture, product, y, multiplies, den/num, |den|,
    // overflow check and one stage per quotient bit.
    localparam int LANE_DEPTH      = 7 + QBITS;

    localparam int LANES_DEF       = 4;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 24;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd1000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NODATA_VALUE  = 2'd0,
        CFG_NODATA_ENABLE = 2'd1,
        CFG_OUTPUT_SCALE  = 2'd2
    } acr_cfg_idx_t;

    typedef struct packed {
        logic                        cmd;
        logic [1:0]                  lane_select;
        logic signed [COEF_BITS-1:0] gain_coef;
        logic signed [COEF_BITS-1:0] offset_coef;
        logic signed [COEF_BITS-1:0] curve_coef;
        logic [1:0]                  source_band;
        logic [15:0]                 sample_0;
        logic [15:0]                 sample_1;
        logic [15:0]                 sample_2;
        logic [15:0]                 sample_3;
    } acr_in_t;

    typedef struct packed {
        logic signed [REFL_BITS-1:0] refl_0;
        logic signed [REFL_BITS-1:0] refl_1;
        logic signed [REFL_BITS-1:0] refl_2;
        logic signed [REFL_BITS-1:0] refl_3;
        logic                        pixel_nodata;
        logic                        saturated;
    } acr_out_t;

    typedef struct packed {
        logic signed [REFL_BITS-1:0] refl;
        logic                        sat;
    } acr_lane_res_t;

endpackage

// ===== rtl/acr_lane.sv =====
`timescale 1ns / 1ps
// One output lane: y = a*x - b, then y*scale / (1 + c*y), rounded and saturated.
// Fully pipelined, restoring divider one quotient bit per stage. Uses acr_pkg.
module acr_lane #(
    parameter int SAMPLE_BITS    = acr_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = acr_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [acr_pkg::COEF_BITS-1:0] gain,
    input  logic signed [acr_pkg::COEF_BITS-1:0] offset,
    input  logic signed [acr_pkg::COEF_BITS-1:0] curve,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  logic [acr_pkg::SCALE_BITS-1:0]       scale,
    input  logic                                 zero_rule,
    output acr_pkg::acr_lane_res_t               res
);
    import acr_pkg::*;

    localparam int F   = COEF_FRAC_BITS;
    localparam int CW  = COEF_BITS;
    localparam int YW  = CW + 1 + SAMPLE_BITS;
    localparam int YHW = YW - F;
    localparam int CHW = CW + YHW;
    localparam int CLW = CW + F + 1;
    localparam int DW  = CHW + 2;
    localparam int HW  = (YW + 1) / 2;
    localparam int LW  = YW - HW;
    localparam int NW  = YW + SCALE_BITS;
    localparam int RW  = ((NW > DW + QBITS) ? NW : DW + QBITS) + 1;

    localparam logic signed [DW-1:0] ONE_Q = {{(DW-1){1'b0}}, 1'b1} << F;
    localparam logic [QBITS:0] POS_LIM =
        {{(QBITS+2-REFL_BITS){1'b0}}, {(REFL_BITS-1){1'b1}}};
    localparam logic [QBITS:0] NEG_LIM = POS_LIM + 1'b1;
    localparam logic signed [REFL_BITS-1:0] REFL_MAX = {1'b0, {(REFL_BITS-1){1'b1}}};
    localparam logic signed [REFL_BITS-1:0] REFL_MIN = {1'b1, {(REFL_BITS-1){1'b0}}};
    localparam logic signed [REFL_BITS-1:0] REFL_ONE = {{(REFL_BITS-1){1'b0}}, 1'b1};

    // capture
    logic signed [CW-1:0]       a1_reg, b1_reg, c1_reg;
    logic [SAMPLE_BITS-1:0]     x1_reg;
    // product
    logic signed [YW-1:0]       prod2_reg;
    logic signed [CW-1:0]       b2_reg, c2_reg;
    // y and |y|
    logic signed [YW-1:0]       y3_reg;
    logic [YW-1:0]              mag3_reg;
    logic signed [CW-1:0]       c3_reg;
    // multiplies
    logic signed [CHW-1:0]      cyh4_reg;
    logic signed [CLW-1:0]      cyl4_reg;
    logic [HW+SCALE_BITS-1:0]   plo4_reg;
    logic [LW+SCALE_BITS-1:0]   phi4_reg;
    logic                       yneg4_reg;
    // divisor and numerator
    logic signed [DW-1:0]       den5_reg;
    logic [NW-1:0]              num5_reg;
    logic                       yneg5_reg;
    // |divisor|
    logic [DW-1:0]              dm6_reg;
    logic [NW-1:0]              num6_reg;
    logic                       dz6_reg, qneg6_reg, yneg6_reg;
    // divider stages
    logic [RW-1:0]              rem_reg  [QBITS+1];
    logic [QBITS-1:0]           q_reg    [QBITS+1];
    logic [DW-1:0]              d_reg    [QBITS+1];
    logic                       ovf_reg  [QBITS+1];
    logic                       dz_reg   [QBITS+1];
    logic                       qneg_reg [QBITS+1];
    logic                       yneg_reg [QBITS+1];

    logic signed [YW-1:0]       y_next;
    logic signed [YHW-1:0]      yh;
    logic [F-1:0]               yl;
    logic signed [DW-1:0]       den_next;

    always_comb
    begin
        y_next   = prod2_reg - YW'(b2_reg);
        yh       = YHW'(y3_reg >>> F);
        yl       = y3_reg[F-1:0];
        den_next = ONE_Q + DW'(cyh4_reg) + DW'(cyl4_reg >>> F);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= gain;
            b1_reg    <= offset;
            c1_reg    <= curve;
            x1_reg    <= sample;

            prod2_reg <= a1_reg * $signed({1'b0, x1_reg});
            b2_reg    <= b1_reg;
            c2_reg    <= c1_reg;

            y3_reg    <= y_next;
            mag3_reg  <= y_next[YW-1] ? YW'(-y_next) : YW'(y_next);
            c3_reg    <= c2_reg;

            cyh4_reg  <= c3_reg * yh;
            cyl4_reg  <= c3_reg * $signed({1'b0, yl});
            plo4_reg  <= mag3_reg[HW-1:0] * scale;
            phi4_reg  <= mag3_reg[YW-1:HW] * scale;
            yneg4_reg <= y3_reg[YW-1];

            den5_reg  <= den_next;
            num5_reg  <= (NW'(phi4_reg) << HW) + NW'(plo4_reg);
            yneg5_reg <= yneg4_reg;

            dm6_reg   <= den5_reg[DW-1] ? DW'(-den5_reg) : DW'(den5_reg);
            num6_reg  <= num5_reg;
            dz6_reg   <= (den5_reg == '0);
            qneg6_reg <= yneg5_reg ^ den5_reg[DW-1];
            yneg6_reg <= yneg5_reg;

            // quotient too large for any quotient bit below QBITS
            rem_reg[0]  <= RW'(num6_reg);
            q_reg[0]    <= '0;
            d_reg[0]    <= dm6_reg;
            ovf_reg[0]  <= RW'(num6_reg) >= (RW'(dm6_reg) << QBITS);
            dz_reg[0]   <= dz6_reg;
            qneg_reg[0] <= qneg6_reg;
            yneg_reg[0] <= yneg6_reg;
        end
    end

    for (genvar j = 1; j <= QBITS; j++)
    begin : g_div
        localparam int K = QBITS - j;
        logic [RW-1:0] shifted;
        logic          ge;

        always_comb
        begin
            shifted = RW'(d_reg[j-1]) << K;
            ge      = rem_reg[j-1] >= shifted;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]   <= ge ? rem_reg[j-1] - shifted : rem_reg[j-1];
                q_reg[j]     <= q_reg[j-1] | (QBITS'(ge) << K);
                d_reg[j]     <= d_reg[j-1];
                ovf_reg[j]   <= ovf_reg[j-1];
                dz_reg[j]    <= dz_reg[j-1];
                qneg_reg[j]  <= qneg_reg[j-1];
                yneg_reg[j]  <= yneg_reg[j-1];
            end
        end
    end

    // round half away from zero, saturate, then apply the zero no-data rule
    logic                        rnd;
    logic [QBITS:0]              qr;
    logic                        below_one;
    logic signed [REFL_BITS-1:0] v;
    logic                        sat;

    always_comb
    begin
        rnd       = {rem_reg[QBITS], 1'b0} >= (RW+1)'(d_reg[QBITS]);
        qr        = {1'b0, q_reg[QBITS]} + (QBITS+1)'(rnd);
        sat       = 1'b0;
        below_one = 1'b0;
        v         = '0;
        if (dz_reg[QBITS])
        begin
            sat       = 1'b1;
            v         = yneg_reg[QBITS] ? REFL_MIN : REFL_MAX;
            below_one = yneg_reg[QBITS];
        end
        else
        begin
            below_one = qneg_reg[QBITS] || (!ovf_reg[QBITS] && q_reg[QBITS] == '0);
            if (qneg_reg[QBITS])
            begin
                if (ovf_reg[QBITS] || qr > NEG_LIM)
                begin
                    sat = 1'b1;
                    v   = REFL_MIN;
                end
                else
                begin
                    v = -$signed(qr[REFL_BITS-1:0]);
                end
            end
            else
            begin
                if (ovf_reg[QBITS] || qr > POS_LIM)
                begin
                    sat = 1'b1;
                    v   = REFL_MAX;
                end
                else
                begin
                    v = $signed(qr[REFL_BITS-1:0]);
                end
            end
        end
        if (zero_rule)
        begin
            if (below_one)
                v = REFL_ONE;
            else if (v == REFL_MAX)
                sat = 1'b1;
            else
                v = v + REFL_ONE;
        end
        res.refl = v;
        res.sat  = sat;
    end

endmodule

// ===== rtl/atmos_coef_reflectance.sv =====
`timescale 1ns / 1ps
// Top level of the reflectance block: coefficient tables, config registers,
// valid pipeline and output register. Uses acr_pkg and acr_lane.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): a transaction with cmd = load
//   writes one lane's gain, offset, curve coefficients and source band and
//   gives no result; a transaction with cmd = pixel carries four samples and
//   gives exactly one result transaction on out_valid/out_ready/out_data.
//   Load every lane before the first pixel; a load takes effect for the
//   next transaction.
//   Config port: cfg_we writes cfg_wdata into the register named by
//   cfg_index (no-data value, no-data enable, output scale) in the same
//   cycle. Write only while no pixel is in flight.
//   Path: an accepted pixel passes through the 32 lane stages and then
//   the output register before it shows on out_valid.
//   Throughput: one pixel per cycle unless stalled; the depth is set by
//   the divider, which resolves one quotient bit per stage.
//   Stall: when the output register holds an untaken result, the whole
//   pipeline and in_ready hold; nothing is dropped or repeated.
//   Reset: clears the valid pipeline and the config registers (no-data
//   value 0, enable 0, scale 1000). Coefficient tables are not cleared.
module atmos_coef_reflectance #(
    parameter int LANES          = acr_pkg::LANES_DEF,
    parameter int SAMPLE_BITS    = acr_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = acr_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  acr_pkg::acr_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output acr_pkg::acr_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [acr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [acr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import acr_pkg::*;

    localparam int HW_LANES = (LANES < NUM_OUT) ? LANES : NUM_OUT;

    // config registers
    logic [NODATA_BITS-1:0] nodata_value_reg;
    logic                   nodata_enable_reg;
    logic [SCALE_BITS-1:0]  output_scale_reg;

    // coefficient tables, undefined until loaded
    logic signed [COEF_BITS-1:0] gain_reg   [HW_LANES];
    logic signed [COEF_BITS-1:0] offset_reg [HW_LANES];
    logic signed [COEF_BITS-1:0] curve_reg  [HW_LANES];
    logic [1:0]                  band_reg   [HW_LANES];

    logic [LANE_DEPTH-1:0] vld_reg;
    logic [LANE_DEPTH-1:0] nd_reg;
    logic                  out_valid_reg;
    acr_out_t              out_data_reg;

    logic                  adv;
    logic                  accept;
    logic                  pix_acc;
    logic                  nodata_in;
    logic                  zero_rule;
    logic [SAMPLE_BITS-1:0] samp [4];
    acr_lane_res_t         lane_res [HW_LANES];
    logic signed [REFL_BITS-1:0] refl_all [NUM_OUT];
    logic                  sat_any;
    acr_out_t              out_next;

    // advance everything whenever the output register is free or drains
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign accept    = in_valid && adv;
    assign pix_acc   = accept && (in_data.cmd == CMD_PIXEL);
    assign zero_rule = nodata_enable_reg && (nodata_value_reg == '0);

    always_comb
    begin
        samp[0]   = in_data.sample_0[SAMPLE_BITS-1:0];
        samp[1]   = in_data.sample_1[SAMPLE_BITS-1:0];
        samp[2]   = in_data.sample_2[SAMPLE_BITS-1:0];
        samp[3]   = in_data.sample_3[SAMPLE_BITS-1:0];
        nodata_in = nodata_enable_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (NODATA_BITS'(samp[i]) != nodata_value_reg)
                nodata_in = 1'b0;
        end
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_value_reg  <= '0;
            nodata_enable_reg <= 1'b0;
            output_scale_reg  <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODATA_VALUE:  nodata_value_reg  <= cfg_wdata[NODATA_BITS-1:0];
                CFG_NODATA_ENABLE: nodata_enable_reg <= cfg_wdata[0];
                CFG_OUTPUT_SCALE:  output_scale_reg  <= cfg_wdata[SCALE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // load transactions write one lane; out-of-range lanes drop
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HW_LANES; i++)
        begin
            if (accept && in_data.cmd == CMD_LOAD && in_data.lane_select == 2'(i))
            begin
                gain_reg[i]   <= in_data.gain_coef;
                offset_reg[i] <= in_data.offset_coef;
                curve_reg[i]  <= in_data.curve_coef;
                band_reg[i]   <= in_data.source_band;
            end
        end
    end

    for (genvar i = 0; i < HW_LANES; i++)
    begin : g_lane
        acr_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .en        (adv),
            .gain      (gain_reg[i]),
            .offset    (offset_reg[i]),
            .curve     (curve_reg[i]),
            .sample    (samp[band_reg[i]]),
            .scale     (output_scale_reg),
            .zero_rule (zero_rule),
            .res       (lane_res[i])
        );
    end

    // assemble the result; no-data pixels and missing lanes read zero
    always_comb
    begin
        sat_any = 1'b0;
        for (int i = 0; i < NUM_OUT; i++)
            refl_all[i] = '0;
        for (int i = 0; i < HW_LANES; i++)
        begin
            if (!nd_reg[LANE_DEPTH-1])
            begin
                refl_all[i] = lane_res[i].refl;
                sat_any     = sat_any | lane_res[i].sat;
            end
        end
        out_next.refl_0       = refl_all[0];
        out_next.refl_1       = refl_all[1];
        out_next.refl_2       = refl_all[2];
        out_next.refl_3       = refl_all[3];
        out_next.pixel_nodata = nd_reg[LANE_DEPTH-1];
        out_next.saturated    = sat_any;
    end

    // valid and no-data flags travel with the lane data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LANE_DEPTH-2:0], pix_acc};
            out_valid_reg <= vld_reg[LANE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nd_reg       <= {nd_reg[LANE_DEPTH-2:0], nodata_in};
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pixel_nodata |->
            out_data.refl_0 == '0 && out_data.refl_1 == '0 &&
            out_data.refl_2 == '0 && out_data.refl_3 == '0 && !out_data.saturated)
        else $error("no-data result carries nonzero payload");

    a_nodata_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !nodata_enable_reg |-> !out_data.pixel_nodata)
        else $error("no-data flag while detection is off");

    a_zero_rule_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_rule && !out_data.pixel_nodata |->
            out_data.refl_0 >= $signed({{(REFL_BITS-1){1'b0}}, 1'b1}))
        else $error("zero no-data rule left a lane below one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(nd_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for atmos_coef_reflectance: directed and random
// coefficient loads and pixels, compared against an in-bench predictor.
// Depends on acr_pkg and the atmos_coef_reflectance RTL only.
module tb;
    import acr_pkg::*;

    localparam int  DRAIN_CYCLES = 45;       // lane pipeline + output register, with margin
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  IN_BITS      = $bits(acr_in_t);
    localparam longint ONE_Q     = 64'sd1 << 24;
    localparam longint REFL_MAX  = 64'sd8388607;
    localparam longint REFL_MIN  = -64'sd8388608;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    acr_in_t     in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    acr_out_t    out_data;
    logic        cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    // Predictor state: lane coefficient tables and register shadows.
    int          gain_q  [4];
    int          offset_q[4];
    int          curve_q [4];
    logic [1:0]  band_sel[4];
    logic [15:0] nodata_val;
    logic        nodata_en;
    logic [15:0] scale_val;

    acr_out_t    pending_refl[$];           // expected pixel results, oldest first
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          cycle_count = 0;

    atmos_coef_reflectance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Bail out on a hang; the limit is far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One lane of the reflectance math: y = a*x - b, y*scale / (1 + c*y),
    // round half away from zero, saturate to 24 bits, then the zero no-data
    // offset rule.
    function automatic longint lane_refl(int lane, logic [15:0] smp[4], inout bit sat);
        longint a, b, c, x, y, yh, yl, den, mag, v;
        longint unsigned num, d, q, r;
        bit neg_num, neg, below_one;
        begin
            a = gain_q[lane];
            b = offset_q[lane];
            c = curve_q[lane];
            x = longint'({48'd0, smp[band_sel[lane]]});
            y = a * x - b;
            // Arithmetic shift floors, which is what the divisor needs.
            yh = y >>> 24;
            yl = y - (yh <<< 24);
            den = ONE_Q + c * yh + ((c * yl) >>> 24);
            mag = (y < 0) ? -y : y;
            num = mag;
            num = num * longint'({48'd0, scale_val});
            neg_num = (y < 0);
            if (den == 0)
            begin
                // Zero divisor: saturate by the sign of y and flag it.
                sat = 1'b1;
                v = neg_num ? REFL_MIN : REFL_MAX;
                below_one = neg_num;
            end
            else
            begin
                neg = neg_num != (den < 0);
                d = (den < 0) ? -den : den;
                q = num / d;
                r = num % d;
                below_one = neg || (num < d);
                if (r >= d - r)
                    q++;
                if (neg)
                begin
                    if (q > 64'd8388608)
                    begin
                        sat = 1'b1;
                        v = REFL_MIN;
                    end
                    else
                        v = -longint'(q);
                end
                else if (q > 64'd8388607)
                begin
                    sat = 1'b1;
                    v = REFL_MAX;
                end
                else
                    v = longint'(q);
            end
            // Zero no-data value: floor at 1, otherwise bump by one.
            if (nodata_en && nodata_val == 16'd0)
            begin
                if (below_one)
                    v = 1;
                else if (v == REFL_MAX)
                    sat = 1'b1;
                else
                    v++;
            end
            lane_refl = v;
        end
    endfunction

    // Advance the predictor by one accepted transaction.
    function automatic void predict_refl(acr_in_t item);
        logic [15:0] smp[4];
        acr_out_t    res;
        bit          sat;
        bit          nd;
        longint      v[4];
        begin
            if (item.cmd == CMD_LOAD)
            begin
                gain_q  [item.lane_select] = item.gain_coef;
                offset_q[item.lane_select] = item.offset_coef;
                curve_q [item.lane_select] = item.curve_coef;
                band_sel[item.lane_select] = item.source_band;
                return;
            end
            smp[0] = item.sample_0;
            smp[1] = item.sample_1;
            smp[2] = item.sample_2;
            smp[3] = item.sample_3;
            nd = nodata_en;
            for (int i = 0; i < 4; i++)
                if (smp[i] != nodata_val)
                    nd = 1'b0;
            sat = 1'b0;
            for (int i = 0; i < 4; i++)
                v[i] = nd ? 0 : lane_refl(i, smp, sat);
            res.refl_0       = v[0][23:0];
            res.refl_1       = v[1][23:0];
            res.refl_2       = v[2][23:0];
            res.refl_3       = v[3][23:0];
            res.pixel_nodata = nd;
            res.saturated    = sat;
            pending_refl.push_back(res);
        end
    endfunction

    // Result checker: compare each accepted result with the oldest
    // expectation, then pick the next ready value for the stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_refl.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                acr_out_t exp_res;
                exp_res = pending_refl.pop_front();
                if (out_data.refl_0 !== exp_res.refl_0 || out_data.refl_1 !== exp_res.refl_1
                    || out_data.refl_2 !== exp_res.refl_2
                    || out_data.refl_3 !== exp_res.refl_3
                    || out_data.pixel_nodata !== exp_res.pixel_nodata
                    || out_data.saturated !== exp_res.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d nd %b sat %b, got %0d %0d %0d %0d nd %b sat %b",
                            exp_res.refl_0, exp_res.refl_1, exp_res.refl_2, exp_res.refl_3,
                            exp_res.pixel_nodata, exp_res.saturated,
                            out_data.refl_0, out_data.refl_1, out_data.refl_2,
                            out_data.refl_3, out_data.pixel_nodata, out_data.saturated);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one transaction: optional idle gap, then hold valid until taken.
    // Valid stays high after acceptance so back-to-back items need no toggle.
    task automatic send_item(acr_in_t item);
        begin
            if ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < send_idle_pct);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do
                @(posedge clk);
            while (!in_ready);
            predict_refl(item);
        end
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain;
        begin
            in_valid <= 1'b0;
            while (pending_refl.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Write one register; the caller drops the write enable afterwards.
    task automatic write_reg(acr_cfg_idx_t idx, logic [15:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge clk);
            case (idx)
                CFG_NODATA_VALUE:  nodata_val = val;
                CFG_NODATA_ENABLE: nodata_en  = val[0];
                CFG_OUTPUT_SCALE:  scale_val  = val;
                default: ;
            endcase
        end
    endtask

    task automatic set_config(logic [15:0] nd_val, logic nd_en, logic [15:0] scale);
        begin
            drain();
            write_reg(CFG_NODATA_VALUE, nd_val);
            write_reg(CFG_NODATA_ENABLE, {15'd0, nd_en});
            write_reg(CFG_OUTPUT_SCALE, scale);
            cfg_we <= 1'b0;
        end
    endtask

    function automatic acr_in_t load_item(int lane, int a, int b, int c, int band);
        acr_in_t it;
        begin
            it = acr_in_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom}));
            it.cmd         = CMD_LOAD;
            it.lane_select = lane[1:0];
            it.gain_coef   = a;
            it.offset_coef = b;
            it.curve_coef  = c;
            it.source_band = band[1:0];
            return it;
        end
    endfunction

    function automatic acr_in_t pixel_item(int s0, int s1, int s2, int s3);
        acr_in_t it;
        begin
            it = acr_in_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom}));
            it.cmd      = CMD_PIXEL;
            it.sample_0 = s0[15:0];
            it.sample_1 = s1[15:0];
            it.sample_2 = s2[15:0];
            it.sample_3 = s3[15:0];
            return it;
        end
    endfunction

    // Random coefficient: mostly physically plausible Q8.24, some raw noise.
    function automatic int rand_coef(int span);
        begin
            if ($urandom_range(3) == 0)
                return int'($urandom);
            return int'($urandom_range(2 * span)) - span;
        end
    endfunction

    function automatic int rand_sample;
        begin
            case ($urandom_range(5))
                0: return nodata_val;
                1: return 0;
                2: return 16'hFFFF;
                default: return $urandom_range(16'hFFFF);
            endcase
        end
    endfunction

    // Loads at field extremes, every band, zero divisor, big saturation.
    task automatic test_directed_edges;
        begin
            send_item(load_item(0, 32'sh0100_0000, 0, 32'shFF00_0000, 0));  // c = -1.0
            send_item(load_item(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1));
            send_item(load_item(2, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 2));
            send_item(load_item(3, 32'sh0000_4000, 32'sh0010_0000, 32'sh0000_8000, 3));
            send_item(pixel_item(1, 1, 1, 1));          // lane 0 divisor is zero
            send_item(pixel_item(0, 0, 0, 0));
            send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
            send_item(pixel_item(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00));
            send_item(load_item(0, 32'shFF00_0000, 0, 32'sh0100_0000, 0));  // y = -1, c = 1
            send_item(pixel_item(1, 2, 3, 4));          // negative y, zero divisor
            send_item(pixel_item(16'hFFFF, 0, 16'hFFFF, 0));
        end
    endtask

    // No-data detection and the zero no-data offset rule.
    task automatic test_nodata_rules;
        begin
            set_config(16'd0, 1'b1, 16'hFFFF);
            send_item(pixel_item(0, 0, 0, 0));
            send_item(pixel_item(0, 0, 0, 1));
            send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
            send_item(pixel_item(1, 1, 1, 1));
            set_config(16'hFFFF, 1'b1, 16'd1);
            send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
            send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF));
            set_config(16'd1234, 1'b0, 16'd0);          // scale zero, detection off
            send_item(pixel_item(1234, 1234, 1234, 1234));
            send_item(pixel_item(1, 1, 1, 1));
        end
    endtask

    // Random mix of pixels and lane reloads under one idle and stall pattern.
    task automatic test_random(int count, int idle_pct, int stall_pct);
        acr_in_t it;
        begin
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(4) == 0)
                    it = load_item($urandom_range(3), rand_coef(32'h0100_0000),
                                   rand_coef(32'h0400_0000), rand_coef(32'h0004_0000),
                                   $urandom_range(3));
                else
                    it = pixel_item(rand_sample(), rand_sample(), rand_sample(),
                                    rand_sample());
                send_item(it);
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_NODATA_VALUE;
        cfg_wdata   <= '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        nodata_val     = 16'd0;
        nodata_en      = 1'b0;
        scale_val      = SCALE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_nodata_rules();

        set_config(16'd0, 1'b0, 16'd1000);
        test_random(400, 0, 0);
        set_config(16'd0, 1'b1, 16'hFFFF);
        test_random(400, 57, 0);
        set_config(16'h0040, 1'b1, 16'd1);
        test_random(400, 0, 57);
        set_config(16'hFFFF, 1'b1, 16'($urandom_range(1, 16'hFFFF)));
        test_random(400, 16, 16);
        set_config(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                   16'($urandom_range(1, 16'hFFFF)));
        test_random(350, 0, 0);

        drain();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
